### rtl/fcpa_pkg.sv
// ----------------------------------------------------------------------------
// Fixed chunk pool allocator package
// Field widths, codes, word types and controller states of the allocator.
// ----------------------------------------------------------------------------
package fcpa_pkg;

   localparam int POOLS_DEF  = 8;
   localparam int CHUNKS_DEF = 1024;

   localparam int POOL_W   = 3;
   localparam int CHUNK_W  = 10;
   localparam int PCOUNT_W = 11;
   localparam int TCOUNT_W = 14;
   localparam int ALLOC_W  = 32;
   localparam int OPEN_W   = 4;
   localparam int LIMIT_W  = 4;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(8);

   typedef enum logic {
      KIND_ALLOC = 1'b0,
      KIND_FREE  = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STAT_DONE    = 2'd0,
      STAT_NOMEM   = 2'd1,
      STAT_NOTUSED = 2'd2
   } status_type;

   typedef struct packed {
      kind_type             kind;
      logic [POOL_W-1:0]    pool_index;
      logic [CHUNK_W-1:0]   chunk_index;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic [POOL_W-1:0]    got_pool;
      logic [CHUNK_W-1:0]   got_chunk;
      logic [PCOUNT_W-1:0]  pool_in_use;
      logic [TCOUNT_W-1:0]  total_in_use;
      logic [TCOUNT_W-1:0]  peak_in_use;
      logic [ALLOC_W-1:0]   lifetime_allocs;
      logic [OPEN_W-1:0]    pools_open;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALLOC_POOL,
      ST_ALLOC_WORD,
      ST_ALLOC_BIT,
      ST_FREE_CHECK,
      ST_FREE_BIT
   } fsm_type;

endpackage

### rtl/fcpa_ram.sv
// ----------------------------------------------------------------------------
// Fixed chunk pool allocator bitmap memory
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module fcpa_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 32,
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/fixed_chunk_pool_allocator.sv
// ----------------------------------------------------------------------------
// Fixed chunk pool allocator
// First-fit allocator of fixed-size chunks over a set of pools on demand.
// ----------------------------------------------------------------------------
//
// Channel     Direction  Handshake                 Word
// request     in         start high, busy low      req_word (fcpa_pkg::req_type)
// response    out        rsp_strobe, one cycle     rsp_word (fcpa_pkg::rsp_type)
// register    in         csr_we                    csr_wdata (pool limit)
//
// An allocate word runs from acceptance to the response strobe in steps set
// by the bitmap memory: one pass picks a pool, one picks a word from the full
// summary and issues the read, and the registered read returns the word,
// whose lowest free bit is then taken and written back. A free word takes
// fewer steps, fewer still when the named chunk lies outside the opened space.
// The response shows in the cycle after the last step, when busy is already
// low, so a new word may be accepted while the response is on the ports.
// Reset is synchronous and needs no clearing pass: a row valid flag per
// bitmap word makes rows never written since reset read as free.
//
module fixed_chunk_pool_allocator #(
   parameter int POOLS  = fcpa_pkg::POOLS_DEF,
   parameter int CHUNKS = fcpa_pkg::CHUNKS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  fcpa_pkg::req_type         req_word,
   output logic                      rsp_strobe,
   output fcpa_pkg::rsp_type         rsp_word,
   input  logic                      csr_we,
   input  logic [fcpa_pkg::LIMIT_W-1:0] csr_wdata
);

   import fcpa_pkg::*;

   // Bitmap geometry: each memory word holds W chunk flags, W a power of two.
   localparam int CI_W   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
   localparam int W      = (CHUNKS >= 32) ? 32 : (1 << CI_W);
   localparam int BI_W   = $clog2(W);
   localparam int WPP    = (CHUNKS + W - 1) / W;
   localparam int WI_W   = (WPP > 1) ? $clog2(WPP) : 1;
   localparam int ROWS   = POOLS * WPP;
   localparam int ADDR_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int PI_W   = (POOLS > 1) ? $clog2(POOLS) : 1;
   localparam int OP_W   = $clog2(POOLS + 1);
   localparam int PC_W   = $clog2(CHUNKS + 1);
   localparam int TC_W   = $clog2(POOLS * CHUNKS + 1);

   fsm_type              state_ff, state_in;
   req_type              req_ff, req_in;
   logic [PI_W-1:0]      pool_ff, pool_in;
   logic [WI_W-1:0]      word_ff, word_in;
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   logic                 new_ff, new_in;
   logic [LIMIT_W-1:0]   limit_ff, limit_in;
   logic [OP_W-1:0]      open_ff, open_in;
   logic [PC_W-1:0]      count_ff [POOLS];
   logic [PC_W-1:0]      count_in [POOLS];
   logic [TC_W-1:0]      total_ff, total_in;
   logic [TC_W-1:0]      peak_ff, peak_in;
   logic [ALLOC_W-1:0]   allocs_ff, allocs_in;
   logic [ROWS-1:0]      valid_ff, valid_in;
   logic [ROWS-1:0]      full_ff, full_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 strobe_ff, strobe_in;

   logic                 ram_we;
   logic [ADDR_W-1:0]    ram_raddr;
   logic [W-1:0]         ram_wdata, ram_rdata;

   logic [POOLS-1:0]     pool_full;
   logic [W-1:0]         rd_word, pad, eff_word;
   logic [CI_W-1:0]      cidx;
   logic [PC_W-1:0]      pcount;

   fcpa_ram #(
      .DEPTH  (ROWS),
      .WIDTH  (W),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (addr_ff),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // A pool is full when every one of its words is marked full.
   for (genvar gp = 0; gp < POOLS; gp++) begin : g_pool_full
      assign pool_full[gp] = &full_ff[gp*WPP +: WPP];
   end

   // The word just read; rows not written since reset read as all free, and
   // flags past the last chunk of a pool count as taken.
   always_comb begin
      rd_word = valid_ff[addr_ff] ? ram_rdata : '0;
      for (int i = 0; i < W; i++) begin
         pad[i] = (int'(word_ff) * W + i) >= CHUNKS;
      end
      eff_word = rd_word | pad;
   end

   assign cidx   = CI_W'(req_ff.chunk_index);
   assign pcount = count_ff[pool_ff];

   always_comb begin
      logic            found;
      logic [PI_W-1:0] fpool;
      logic [WI_W-1:0] fword;
      logic [BI_W-1:0] fbit;
      logic [W-1:0]    new_word;
      logic            bad;

      state_in  = state_ff;
      req_in    = req_ff;
      pool_in   = pool_ff;
      word_in   = word_ff;
      addr_in   = addr_ff;
      new_in    = new_ff;
      limit_in  = csr_we ? csr_wdata : limit_ff;
      open_in   = open_ff;
      count_in  = count_ff;
      total_in  = total_ff;
      peak_in   = peak_ff;
      allocs_in = allocs_ff;
      valid_in  = valid_ff;
      full_in   = full_ff;
      rsp_in    = rsp_ff;
      strobe_in = 1'b0;
      ram_we    = 1'b0;
      ram_wdata = '0;
      ram_raddr = addr_ff;
      found     = 1'b0;
      fpool     = '0;
      fword     = '0;
      fbit      = '0;
      new_word  = '0;
      bad       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_word;
               state_in = (req_word.kind == KIND_FREE) ? ST_FREE_CHECK : ST_ALLOC_POOL;
            end
         end

         ST_ALLOC_POOL: begin
            for (int p = POOLS - 1; p >= 0; p--) begin
               if (p < int'(open_ff) && !pool_full[p]) begin
                  found = 1'b1;
                  fpool = PI_W'(p);
               end
            end
            if (found) begin
               pool_in  = fpool;
               new_in   = 1'b0;
               state_in = ST_ALLOC_WORD;
            end else if (int'(open_ff) < int'(limit_ff) && int'(open_ff) < POOLS) begin
               pool_in  = PI_W'(open_ff);
               new_in   = 1'b1;
               state_in = ST_ALLOC_WORD;
            end else begin
               rsp_in.status          = STAT_NOMEM;
               rsp_in.got_pool        = '0;
               rsp_in.got_chunk       = '0;
               rsp_in.pool_in_use     = '0;
               rsp_in.total_in_use    = TCOUNT_W'(total_ff);
               rsp_in.peak_in_use     = TCOUNT_W'(peak_ff);
               rsp_in.lifetime_allocs = allocs_ff;
               rsp_in.pools_open      = OPEN_W'(open_ff);
               strobe_in              = 1'b1;
               state_in               = ST_IDLE;
            end
         end

         ST_ALLOC_WORD: begin
            for (int w = WPP - 1; w >= 0; w--) begin
               if (!full_ff[int'(pool_ff) * WPP + w]) begin
                  fword = WI_W'(w);
               end
            end
            word_in   = fword;
            addr_in   = ADDR_W'(int'(pool_ff) * WPP + int'(fword));
            ram_raddr = addr_in;
            state_in  = ST_ALLOC_BIT;
         end

         ST_ALLOC_BIT: begin
            for (int b = W - 1; b >= 0; b--) begin
               if (!eff_word[b]) begin
                  fbit = BI_W'(b);
               end
            end
            new_word           = rd_word;
            new_word[fbit]     = 1'b1;
            ram_we             = 1'b1;
            ram_wdata          = new_word;
            valid_in[addr_ff]  = 1'b1;
            full_in[addr_ff]   = &(new_word | pad);
            count_in[pool_ff]  = pcount + 1'b1;
            total_in           = total_ff + 1'b1;
            peak_in            = (total_in > peak_ff) ? total_in : peak_ff;
            allocs_in          = (&allocs_ff) ? allocs_ff : allocs_ff + 1'b1;
            if (new_ff) begin
               open_in = open_ff + 1'b1;
            end
            rsp_in.status          = STAT_DONE;
            rsp_in.got_pool        = POOL_W'(pool_ff);
            rsp_in.got_chunk       = CHUNK_W'(int'(word_ff) * W + int'(fbit));
            rsp_in.pool_in_use     = PCOUNT_W'(count_in[pool_ff]);
            rsp_in.total_in_use    = TCOUNT_W'(total_in);
            rsp_in.peak_in_use     = TCOUNT_W'(peak_in);
            rsp_in.lifetime_allocs = allocs_in;
            rsp_in.pools_open      = OPEN_W'(open_in);
            strobe_in              = 1'b1;
            state_in               = ST_IDLE;
         end

         ST_FREE_CHECK: begin
            bad = int'(req_ff.pool_index) >= POOLS
               || int'(req_ff.pool_index) >= int'(open_ff)
               || int'(req_ff.chunk_index) >= CHUNKS;
            pool_in   = PI_W'(req_ff.pool_index);
            word_in   = WI_W'(cidx >> BI_W);
            addr_in   = ADDR_W'(int'(pool_in) * WPP + int'(word_in));
            ram_raddr = addr_in;
            if (bad) begin
               rsp_in.status          = STAT_NOTUSED;
               rsp_in.got_pool        = req_ff.pool_index;
               rsp_in.got_chunk       = req_ff.chunk_index;
               rsp_in.pool_in_use     = (int'(req_ff.pool_index) >= POOLS) ? '0
                                        : PCOUNT_W'(count_ff[pool_in]);
               rsp_in.total_in_use    = TCOUNT_W'(total_ff);
               rsp_in.peak_in_use     = TCOUNT_W'(peak_ff);
               rsp_in.lifetime_allocs = allocs_ff;
               rsp_in.pools_open      = OPEN_W'(open_ff);
               strobe_in              = 1'b1;
               state_in               = ST_IDLE;
            end else begin
               state_in = ST_FREE_BIT;
            end
         end

         ST_FREE_BIT: begin
            fbit = BI_W'(cidx);
            rsp_in.got_pool        = req_ff.pool_index;
            rsp_in.got_chunk       = req_ff.chunk_index;
            if (rd_word[fbit]) begin
               new_word          = rd_word;
               new_word[fbit]    = 1'b0;
               ram_we            = 1'b1;
               ram_wdata         = new_word;
               valid_in[addr_ff] = 1'b1;
               full_in[addr_ff]  = 1'b0;
               count_in[pool_ff] = pcount - 1'b1;
               total_in          = total_ff - 1'b1;
               rsp_in.status     = STAT_DONE;
            end else begin
               rsp_in.status     = STAT_NOTUSED;
            end
            rsp_in.pool_in_use     = PCOUNT_W'(count_in[pool_ff]);
            rsp_in.total_in_use    = TCOUNT_W'(total_in);
            rsp_in.peak_in_use     = TCOUNT_W'(peak_ff);
            rsp_in.lifetime_allocs = allocs_ff;
            rsp_in.pools_open      = OPEN_W'(open_ff);
            strobe_in              = 1'b1;
            state_in               = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The write-back happens in the last state of an item and the idle state
   // comes before the next read, so reads never meet a pending write.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         limit_ff  <= LIMIT_RESET;
         open_ff   <= '0;
         total_ff  <= '0;
         peak_ff   <= '0;
         allocs_ff <= '0;
         valid_ff  <= '0;
         full_ff   <= '0;
         strobe_ff <= 1'b0;
         for (int p = 0; p < POOLS; p++) begin
            count_ff[p] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         limit_ff  <= limit_in;
         open_ff   <= open_in;
         total_ff  <= total_in;
         peak_ff   <= peak_in;
         allocs_ff <= allocs_in;
         valid_ff  <= valid_in;
         full_ff   <= full_in;
         strobe_ff <= strobe_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      pool_ff <= pool_in;
      word_ff <= word_in;
      addr_ff <= addr_in;
      new_ff  <= new_in;
      rsp_ff  <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule

### rtl/fcpa_checker.sv
// ----------------------------------------------------------------------------
// Fixed chunk pool allocator checker
// Port-level properties of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fcpa_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_strobe,
   input fcpa_pkg::rsp_type    rsp_word
);

   import fcpa_pkg::*;

   // An accepted word keeps the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   // A response only shows once the block has gone idle.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response strobe while busy");

   // Every end of work carries a response.
   a_fall_strobe: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_strobe)
      else $error("busy fell without a response");

   // Responses are never back to back.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two responses in a row");

   // An out-of-memory response names no chunk.
   a_nomem_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_word.status == STAT_NOMEM |->
         rsp_word.got_pool == '0 && rsp_word.got_chunk == '0)
      else $error("out-of-memory response names a chunk");

endmodule

bind fixed_chunk_pool_allocator fcpa_checker u_fcpa_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_word   (rsp_word)
);

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fixed chunk pool allocator testbench
// Drives allocate and free words into the allocator, predicts every response
// from a behavioural copy of the pool bitmap and counters, and compares each
// response field by field, over several pool limit settings.
// ----------------------------------------------------------------------------
module tb_top;
   import fcpa_pkg::*;

   localparam int NPOOLS  = POOLS_DEF;
   localparam int NCHUNKS = CHUNKS_DEF;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_word = '0;
   logic rsp_strobe;
   rsp_type rsp_word;
   logic csr_we = 1'b0;
   logic [LIMIT_W-1:0] csr_wdata = '0;

   fixed_chunk_pool_allocator u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_strobe(rsp_strobe), .rsp_word(rsp_word),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shadow state of the allocator, updated as each word is accepted.
   bit                  chunk_used [NPOOLS][NCHUNKS];
   int unsigned         pools_opened;
   int unsigned         pool_count [NPOOLS];
   int unsigned         chunks_taken;
   int unsigned         chunks_peak;
   logic [ALLOC_W-1:0]  alloc_count;
   int unsigned         limit_now;

   // Words waiting to be sent, and responses predicted but not yet seen.
   req_type  pending_words [$];
   rsp_type  expected_rsps [$];
   // Chunks the model holds in use, so frees can name live chunks.
   int unsigned live_chunks [$];

   int  mismatches = 0;
   int  cycles = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   function automatic void reset_shadow();
      foreach (chunk_used[p, c]) chunk_used[p][c] = 1'b0;
      foreach (pool_count[p]) pool_count[p] = 0;
      pools_opened = 0;
      chunks_taken = 0;
      chunks_peak = 0;
      alloc_count = '0;
      limit_now = 8;
      live_chunks.delete();
   endfunction

   function automatic void claim_chunk(input int unsigned p, input int unsigned c);
      chunk_used[p][c] = 1'b1;
      pool_count[p]++;
      chunks_taken++;
      if (chunks_taken > chunks_peak) chunks_peak = chunks_taken;
      if (alloc_count != '1) alloc_count++;
      live_chunks.push_back(p * NCHUNKS + c);
   endfunction

   // Works out the response to one word and advances the shadow state.
   function automatic rsp_type allocator_response(input req_type w);
      rsp_type r;
      int unsigned p, c, lim;
      bit found;
      r = '0;
      r.status = STAT_DONE;
      found = 1'b0;
      if (w.kind == KIND_ALLOC) begin
         for (p = 0; p < pools_opened && !found; p++) begin
            for (c = 0; c < NCHUNKS && !found; c++) begin
               if (!chunk_used[p][c]) begin
                  claim_chunk(p, c);
                  r.got_pool = POOL_W'(p);
                  r.got_chunk = CHUNK_W'(c);
                  r.pool_in_use = PCOUNT_W'(pool_count[p]);
                  found = 1'b1;
               end
            end
         end
         if (!found) begin
            lim = (limit_now < NPOOLS) ? limit_now : NPOOLS;
            if (pools_opened < lim) begin
               p = pools_opened;
               for (c = 0; c < NCHUNKS; c++) chunk_used[p][c] = 1'b0;
               pool_count[p] = 0;
               pools_opened++;
               claim_chunk(p, 0);
               r.got_pool = POOL_W'(p);
               r.got_chunk = '0;
               r.pool_in_use = PCOUNT_W'(pool_count[p]);
            end else begin
               r.status = STAT_NOMEM;
            end
         end
      end else begin
         p = 32'(w.pool_index);
         c = 32'(w.chunk_index);
         r.got_pool = w.pool_index;
         r.got_chunk = w.chunk_index;
         if (p >= pools_opened || !chunk_used[p][c]) begin
            r.status = STAT_NOTUSED;
            r.pool_in_use = PCOUNT_W'(pool_count[p]);
         end else begin
            chunk_used[p][c] = 1'b0;
            pool_count[p]--;
            chunks_taken--;
            r.pool_in_use = PCOUNT_W'(pool_count[p]);
            foreach (live_chunks[i])
               if (live_chunks[i] == p * NCHUNKS + c) begin
                  live_chunks.delete(i);
                  break;
               end
         end
      end
      r.total_in_use = TCOUNT_W'(chunks_taken);
      r.peak_in_use = TCOUNT_W'(chunks_peak);
      r.lifetime_allocs = alloc_count;
      r.pools_open = OPEN_W'(pools_opened);
      return r;
   endfunction

   // Driver: one word at a time from the pending queue, with a random gap
   // drawn per word. Start stays high until the block accepts the word.
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy) begin
         // Accepted at this edge; predict now, against state as of acceptance.
         expected_rsps.push_back(allocator_response(req_word));
         void'(pending_words.pop_front());
         gap_left = $urandom_range(0, 8);
         if (gap_left == 0 && pending_words.size() > 0) begin
            req_word <= pending_words[0];
         end else begin
            start <= 1'b0;
         end
      end else if (!start && pending_words.size() > 0) begin
         if (gap_left > 0) begin
            gap_left--;
         end else begin
            req_word <= pending_words[0];
            start <= 1'b1;
         end
      end
   end

   // Monitor: every strobe is checked against the oldest prediction.
   always @(posedge clock) begin
      cycles++;
      if (!reset && rsp_strobe) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("response with none expected", 0, 0);
         end else begin
            rsp_type e;
            e = expected_rsps.pop_front();
            if (rsp_word.status !== e.status)
               report_mismatch("status", 32'(rsp_word.status), 32'(e.status));
            if (rsp_word.got_pool !== e.got_pool)
               report_mismatch("got_pool", 32'(rsp_word.got_pool), 32'(e.got_pool));
            if (rsp_word.got_chunk !== e.got_chunk)
               report_mismatch("got_chunk", 32'(rsp_word.got_chunk), 32'(e.got_chunk));
            if (rsp_word.pool_in_use !== e.pool_in_use)
               report_mismatch("pool_in_use", 32'(rsp_word.pool_in_use),
                               32'(e.pool_in_use));
            if (rsp_word.total_in_use !== e.total_in_use)
               report_mismatch("total_in_use", 32'(rsp_word.total_in_use),
                               32'(e.total_in_use));
            if (rsp_word.peak_in_use !== e.peak_in_use)
               report_mismatch("peak_in_use", 32'(rsp_word.peak_in_use),
                               32'(e.peak_in_use));
            if (rsp_word.lifetime_allocs !== e.lifetime_allocs)
               report_mismatch("lifetime_allocs", rsp_word.lifetime_allocs,
                               e.lifetime_allocs);
            if (rsp_word.pools_open !== e.pools_open)
               report_mismatch("pools_open", 32'(rsp_word.pools_open), 32'(e.pools_open));
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic req_type alloc_word();
      req_type w;
      w.kind = KIND_ALLOC;
      w.pool_index = POOL_W'($urandom_range(0, 7));
      w.chunk_index = CHUNK_W'($urandom_range(0, NCHUNKS - 1));
      return w;
   endfunction

   function automatic req_type free_word(input int unsigned p, input int unsigned c);
      req_type w;
      w.kind = KIND_FREE;
      w.pool_index = POOL_W'(p);
      w.chunk_index = CHUNK_W'(c);
      return w;
   endfunction

   // Waits until every queued word has been accepted and answered, then lets
   // the block settle before the next register write.
   task automatic drain();
      while (pending_words.size() > 0 || start || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limit(input int unsigned value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= LIMIT_W'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      limit_now = value;
   endtask

   // A phase of random traffic. Frees on a roll below 92 name a live chunk; the
   // rest are random and mostly hit chunks not in use or pools not opened.
   task automatic random_phase(input int unsigned count, input int unsigned alloc_pct);
      int unsigned k, pick, roll;
      for (k = 0; k < count; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < alloc_pct) begin
            pending_words.push_back(alloc_word());
         end else if (roll < 92 && live_chunks.size() > 0) begin
            // Wait until the shadow state holds the chunk before naming it.
            while (pending_words.size() > 0 || start) @(posedge clock);
            pick = live_chunks[$urandom_range(0, live_chunks.size() - 1)];
            pending_words.push_back(free_word(pick / NCHUNKS, pick % NCHUNKS));
         end else begin
            pending_words.push_back(free_word($urandom_range(0, 7),
                                              $urandom_range(0, NCHUNKS - 1)));
         end
      end
      drain();
   endtask

   initial begin
      reset_shadow();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part: free before any pool is open, the extreme indices,
      // allocations opening pool 0, a double free and a free of a live chunk.
      pending_words.push_back(free_word(0, 0));
      pending_words.push_back(free_word(7, NCHUNKS - 1));
      pending_words.push_back(alloc_word());
      pending_words.push_back(alloc_word());
      pending_words.push_back(free_word(0, 1));
      pending_words.push_back(free_word(0, 1));
      pending_words.push_back(alloc_word());
      pending_words.push_back(free_word(0, NCHUNKS - 1));
      pending_words.push_back(free_word(5, 0));
      pending_words.push_back(free_word(0, 0));
      pending_words.push_back(alloc_word());
      drain();

      // Limit of zero while a pool is open: pool 0 still serves, no new pool.
      write_limit(0);
      random_phase(20, 70);

      // A limit of one with a full pool: fill pool 0 up to and past its
      // last chunk, so the final allocations report no memory.
      write_limit(1);
      random_phase(NCHUNKS + 10, 100);
      random_phase(25, 30);

      // Limit above the number of pools is treated as the number of pools;
      // once the holes in pool 0 are refilled, pool 1 opens.
      write_limit(15);
      random_phase(60, 85);

      // Lowered below the open pools: those pools stay usable.
      write_limit(1);
      random_phase(40, 55);

      write_limit(8);
      random_phase(30, 60);

      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
